// ----- rtl/sorted_table_binary_search_unit_assert.svh -----
// assertion macros for the sorted table binary search unit checker
`ifndef SORTED_TABLE_BINARY_SEARCH_UNIT_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication on the checker clock
`define SBS_CHECK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbs checker: same-cycle rule violated");

// next-cycle implication on the checker clock
`define SBS_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbs checker: next-cycle rule violated");

`endif

// ----- rtl/sbs_pkg.sv -----
// shared constants, types and helpers for the sorted table binary search unit
`default_nettype none

package sbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int FIELD_W     = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = CNT_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 1'b1;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    localparam logic MODE_EXACT = 1'b0;
    localparam logic MODE_LEFT  = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_EXACT,
        OP_LEFT,
        OP_MISS
    } op_t;

    typedef struct packed {
        op_t                            op;
        logic [IDX_W-1:0]               idx;
        logic signed [VALUE_WIDTH-1:0]  value;
        logic [CNT_W-1:0]               count;
    } item_t;

    // sign-extend a field to 64 bits, then wrap to the table value width
    function automatic logic signed [VALUE_WIDTH-1:0] to_value(input logic [FIELD_W-1:0] f);
        logic [63:0] ext;
        ext = {{(64 - FIELD_W){f[FIELD_W-1]}}, f};
        return ext[VALUE_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sbs_front.sv -----
// front end: configuration registers, request acceptance and classification
`default_nettype none

module sbs_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                req_type,
    input  wire logic [sbs_pkg::IDX_W-1:0]           entry_index,
    input  wire logic signed [sbs_pkg::FIELD_W-1:0]  entry_value,
    input  wire logic signed [sbs_pkg::FIELD_W-1:0]  search_key,
    input  wire logic                                cfg_wr_en,
    input  wire logic [sbs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [sbs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire logic                                queue_full,
    output logic                                     push,
    output sbs_pkg::item_t                           item
);

    logic [sbs_pkg::CNT_W-1:0] entries_reg;
    logic                      mode_reg;
    logic [sbs_pkg::CNT_W-1:0] count_sat;
    logic                      in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= '0;
            mode_reg    <= sbs_pkg::MODE_EXACT;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                sbs_pkg::REG_ENTRIES: entries_reg <= cfg_wdata[sbs_pkg::CNT_W-1:0];
                sbs_pkg::REG_MODE:    mode_reg    <= cfg_wdata[0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        count_sat = (entries_reg > sbs_pkg::CNT_W'(sbs_pkg::TABLE_DEPTH))
                  ? sbs_pkg::CNT_W'(sbs_pkg::TABLE_DEPTH) : entries_reg;
        in_range  = (sbs_pkg::CNT_W'(entry_index) < sbs_pkg::CNT_W'(sbs_pkg::TABLE_DEPTH));

        busy = queue_full;

        item.idx   = entry_index;
        item.count = count_sat;
        if (req_type == sbs_pkg::REQ_WRITE)
        begin
            item.op    = sbs_pkg::OP_WRITE;
            item.value = sbs_pkg::to_value(entry_value);
        end
        else
        begin
            item.value = sbs_pkg::to_value(search_key);
            if (count_sat == '0)
                item.op = sbs_pkg::OP_MISS;
            else if (mode_reg == sbs_pkg::MODE_LEFT)
                item.op = sbs_pkg::OP_LEFT;
            else
                item.op = sbs_pkg::OP_EXACT;
        end

        // out-of-range writes are dropped here
        push = start && !queue_full && (req_type == sbs_pkg::REQ_SEARCH || in_range);
    end

endmodule

`default_nettype wire

// ----- rtl/sbs_queue.sv -----
// short fifo of classified transactions between front and back
`default_nettype none

module sbs_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire sbs_pkg::item_t  item_in,
    input  wire logic            pop,
    output sbs_pkg::item_t       item_out,
    output logic                 empty,
    output logic                 full
);

    sbs_pkg::item_t               slot_reg [sbs_pkg::QUEUE_DEPTH];
    logic [sbs_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [sbs_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [sbs_pkg::QCNT_W-1:0]   count_reg;
    logic                         do_push;
    logic                         do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == sbs_pkg::QCNT_W'(sbs_pkg::QUEUE_DEPTH));
    assign item_out = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + sbs_pkg::QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + sbs_pkg::QPTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + sbs_pkg::QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - sbs_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= item_in;
    end

endmodule

`default_nettype wire

// ----- rtl/sbs_back.sv -----
// back end: table memory and one-probe-per-cycle binary search sequencer
`default_nettype none

module sbs_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_empty,
    input  wire sbs_pkg::item_t              q_item,
    output logic                             pop,
    output logic                             done,
    output logic                             found,
    output logic [sbs_pkg::IDX_W-1:0]        position
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CHECK
    } state_t;

    state_t                                state_reg, state_next;
    logic [sbs_pkg::CNT_W-1:0]             lo_reg, lo_next;
    logic [sbs_pkg::CNT_W-1:0]             hi_reg, hi_next;
    logic [sbs_pkg::CNT_W-1:0]             n_reg, n_next;
    logic [sbs_pkg::IDX_W-1:0]             mid_reg, mid_next;
    logic signed [sbs_pkg::VALUE_WIDTH-1:0] key_reg, key_next;
    logic                                  left_reg, left_next;
    logic                                  done_reg, done_next;
    logic                                  found_reg, found_next;
    logic [sbs_pkg::IDX_W-1:0]             position_reg, position_next;

    logic signed [sbs_pkg::VALUE_WIDTH-1:0] mem [sbs_pkg::TABLE_DEPTH];
    logic signed [sbs_pkg::VALUE_WIDTH-1:0] rd_data_reg;
    logic                                  rd_en;
    logic [sbs_pkg::IDX_W-1:0]             rd_addr;
    logic                                  wr_en;

    logic                                  probe_eq;
    logic                                  probe_lt;
    logic [sbs_pkg::CNT_W-1:0]             lo_step;
    logic [sbs_pkg::CNT_W-1:0]             hi_step;
    logic [sbs_pkg::CNT_W-1:0]             span;
    logic [sbs_pkg::CNT_W-1:0]             mid_step;
    logic [sbs_pkg::CNT_W-1:0]             mid_first;

    assign done     = done_reg;
    assign found    = found_reg;
    assign position = position_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[q_item.idx] <= q_item.value;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        probe_eq  = (rd_data_reg == key_reg);
        probe_lt  = (rd_data_reg < key_reg);
        lo_step   = probe_lt ? (sbs_pkg::CNT_W'(mid_reg) + sbs_pkg::CNT_W'(1)) : lo_reg;
        hi_step   = probe_lt ? hi_reg : sbs_pkg::CNT_W'(mid_reg);
        span      = hi_step - lo_step - sbs_pkg::CNT_W'(1);
        mid_step  = lo_step + (span >> 1);
        mid_first = (q_item.count - sbs_pkg::CNT_W'(1)) >> 1;

        state_next    = state_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        n_next        = n_reg;
        mid_next      = mid_reg;
        key_next      = key_reg;
        left_next     = left_reg;
        done_next     = 1'b0;
        found_next    = 1'b0;
        position_next = '0;
        pop           = 1'b0;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = mid_step[sbs_pkg::IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    case (q_item.op)
                        sbs_pkg::OP_WRITE: wr_en = 1'b1;
                        sbs_pkg::OP_MISS:  done_next = 1'b1;
                        default:
                        begin
                            lo_next    = '0;
                            hi_next    = q_item.count;
                            n_next     = q_item.count;
                            key_next   = q_item.value;
                            left_next  = (q_item.op == sbs_pkg::OP_LEFT);
                            mid_next   = mid_first[sbs_pkg::IDX_W-1:0];
                            rd_en      = 1'b1;
                            rd_addr    = mid_first[sbs_pkg::IDX_W-1:0];
                            state_next = S_PROBE;
                        end
                    endcase
                end
            end
            S_PROBE:
            begin
                if (!left_reg && probe_eq)
                begin
                    done_next     = 1'b1;
                    found_next    = 1'b1;
                    position_next = mid_reg;
                    state_next    = S_IDLE;
                end
                else
                begin
                    lo_next = lo_step;
                    hi_next = hi_step;
                    if (lo_step < hi_step)
                    begin
                        mid_next = mid_step[sbs_pkg::IDX_W-1:0];
                        rd_en    = 1'b1;
                    end
                    else if (left_reg && lo_step < n_reg)
                    begin
                        mid_next   = lo_step[sbs_pkg::IDX_W-1:0];
                        rd_en      = 1'b1;
                        rd_addr    = lo_step[sbs_pkg::IDX_W-1:0];
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_CHECK:
            begin
                done_next     = 1'b1;
                found_next    = probe_eq;
                position_next = probe_eq ? mid_reg : '0;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            lo_reg       <= '0;
            hi_reg       <= '0;
            n_reg        <= '0;
            mid_reg      <= '0;
            key_reg      <= '0;
            left_reg     <= 1'b0;
            done_reg     <= 1'b0;
            found_reg    <= 1'b0;
            position_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            n_reg        <= n_next;
            mid_reg      <= mid_next;
            key_reg      <= key_next;
            left_reg     <= left_next;
            done_reg     <= done_next;
            found_reg    <= found_next;
            position_reg <= position_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sorted_table_binary_search_unit.sv -----
// top level of the sorted table binary search unit
//
//   channel   handshake            payload
//   request   start / busy         req_type, entry_index, entry_value, search_key
//   result    done (strobe)        found, position
//   config    cfg_wr_en            cfg_index, cfg_wdata
//
// a search leaves the queue, probes the table one entry at a time through the single read
// port of the table memory, adds one more probe for a leftmost search that still has an
// entry to check, and passes through a result register before done; a write passes through
// the queue, reaches the table when the back end pops it and gives no result.
// a two-entry queue takes requests during a search; busy is high only while it is full.
// reset clears control and both registers, not the table; done is a one-cycle strobe.
`default_nettype none

module sorted_table_binary_search_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                req_type,
    input  wire logic [sbs_pkg::IDX_W-1:0]           entry_index,
    input  wire logic signed [sbs_pkg::FIELD_W-1:0]  entry_value,
    input  wire logic signed [sbs_pkg::FIELD_W-1:0]  search_key,
    input  wire logic                                cfg_wr_en,
    input  wire logic [sbs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [sbs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output logic                                     done,
    output logic                                     found,
    output logic [sbs_pkg::IDX_W-1:0]                position
);

    sbs_pkg::item_t front_item;
    sbs_pkg::item_t back_item;
    logic           push;
    logic           pop;
    logic           q_empty;
    logic           q_full;

    sbs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .search_key  (search_key),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .queue_full  (q_full),
        .push        (push),
        .item        (front_item)
    );

    sbs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (front_item),
        .pop      (pop),
        .item_out (back_item),
        .empty    (q_empty),
        .full     (q_full)
    );

    sbs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (back_item),
        .pop      (pop),
        .done     (done),
        .found    (found),
        .position (position)
    );

endmodule

`default_nettype wire

// ----- rtl/sbs_checker.sv -----
// port-level checker for the sorted table binary search unit, with its bind
`default_nettype none

`include "sorted_table_binary_search_unit_assert.svh"

module sbs_checker (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic                      busy,
    input  wire logic                      done,
    input  wire logic                      found,
    input  wire logic [sbs_pkg::IDX_W-1:0] position
);

    // result fields are quiet outside a result transaction
    `SBS_CHECK_NOW(a_found_only_on_done, !done, !found)
    // a miss reports position zero
    `SBS_CHECK_NOW(a_miss_position_zero, !done || !found, position == '0)
    // the queue only fills through an accepted transaction
    `SBS_CHECK_NOW(a_busy_rise_needs_start, $rose(busy), $past(start))
    // with no request offered an idle front stays open
    `SBS_CHECK_NEXT(a_no_start_stays_open, !start && !busy, !busy)

endmodule

bind sorted_table_binary_search_unit sbs_checker u_sbs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .found    (found),
    .position (position)
);

`default_nettype wire

// ----- bench/sbs_search_checker.sv -----
// checker for the search unit: mirrors table and registers, predicts each answer, compares results
module sbs_search_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic                                 req_type,
    input  logic [sbs_pkg::IDX_W-1:0]            entry_index,
    input  logic signed [sbs_pkg::FIELD_W-1:0]   entry_value,
    input  logic signed [sbs_pkg::FIELD_W-1:0]   search_key,
    input  logic                                 cfg_wr_en,
    input  logic [sbs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sbs_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                 done,
    input  logic                                 found,
    input  logic [sbs_pkg::IDX_W-1:0]            position,
    output int                                   errors,
    output int                                   answers_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                        found;
        logic [sbs_pkg::IDX_W-1:0]   position;
    } search_answer_t;

    logic signed [sbs_pkg::VALUE_WIDTH-1:0] shadow_table [sbs_pkg::TABLE_DEPTH];
    logic [sbs_pkg::CNT_W-1:0]              entries_cfg;
    logic                                   mode_cfg;
    search_answer_t                         expected_answers [$];

    function automatic search_answer_t lookup_key(
        input logic signed [sbs_pkg::VALUE_WIDTH-1:0] key);
        search_answer_t ans;
        int unsigned    span;
        int unsigned    lo;
        int unsigned    hi;
        int unsigned    mid;
        ans = '0;
        span = (entries_cfg > sbs_pkg::TABLE_DEPTH) ? sbs_pkg::TABLE_DEPTH : entries_cfg;
        lo = 0;
        hi = span;
        if (mode_cfg == sbs_pkg::MODE_EXACT)
        begin
            while (lo < hi && !ans.found)
            begin
                mid = lo + (hi - lo - 1) / 2;
                if (shadow_table[mid] == key)
                begin
                    ans.found = 1'b1;
                    ans.position = sbs_pkg::IDX_W'(mid);
                end
                else if (shadow_table[mid] < key)
                    lo = mid + 1;
                else
                    hi = mid;
            end
        end
        else
        begin
            while (lo < hi)
            begin
                mid = lo + (hi - lo - 1) / 2;
                if (shadow_table[mid] < key)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            if (lo < span && shadow_table[lo] == key)
            begin
                ans.found = 1'b1;
                ans.position = sbs_pkg::IDX_W'(lo);
            end
        end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        search_answer_t want;
        if (!rst_n)
        begin
            entries_cfg = '0;
            mode_cfg = sbs_pkg::MODE_EXACT;
            expected_answers.delete();
            answers_waiting = 0;
        end
        else
        begin
            // results first: an answer can never belong to a search accepted at this edge
            if (done)
            begin
                if (expected_answers.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no search waiting: found=%0b position=%0d",
                             $time, found, position);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (found !== want.found)
                    begin
                        errors++;
                        $display("%0t: found expected %0b actual %0b",
                                 $time, want.found, found);
                    end
                    if (position !== want.position)
                    begin
                        errors++;
                        $display("%0t: position expected %0d actual %0d",
                                 $time, want.position, position);
                    end
                end
            end
            if (cfg_wr_en)
            begin
                if (cfg_index == sbs_pkg::REG_ENTRIES)
                    entries_cfg = cfg_wdata;
                else if (cfg_index == sbs_pkg::REG_MODE)
                    mode_cfg = cfg_wdata[0];
            end
            if (start && !busy)
            begin
                if (req_type == sbs_pkg::REQ_WRITE)
                    shadow_table[entry_index] = sbs_pkg::VALUE_WIDTH'(entry_value);
                else
                    expected_answers.push_back(
                        lookup_key(sbs_pkg::VALUE_WIDTH'(search_key)));
            end
            answers_waiting = expected_answers.size();
        end
    end

endmodule

// ----- bench/tb_sorted_table_binary_search_unit.sv -----
// testbench top for the sorted table binary search unit: stimulus, timeout and verdict
module tb_sorted_table_binary_search_unit ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CYCLE_LIMIT  = 1000000;
    localparam int     RANDOM_ITEMS = 450;
    localparam longint MAX_L        = 64'sh7FFF_FFFF;
    localparam longint MIN_L        = -64'sh8000_0000;
    localparam logic signed [sbs_pkg::FIELD_W-1:0] MAX_VALUE = 32'sh7FFF_FFFF;
    localparam logic signed [sbs_pkg::FIELD_W-1:0] MIN_VALUE = 32'sh8000_0000;

    logic                                clk;
    logic                                rst_n;
    logic                                start;
    logic                                busy;
    logic                                req_type;
    logic [sbs_pkg::IDX_W-1:0]           entry_index;
    logic signed [sbs_pkg::FIELD_W-1:0]  entry_value;
    logic signed [sbs_pkg::FIELD_W-1:0]  search_key;
    logic                                cfg_wr_en;
    logic [sbs_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [sbs_pkg::CFG_DATA_W-1:0]      cfg_wdata;
    logic                                done;
    logic                                found;
    logic [sbs_pkg::IDX_W-1:0]           position;

    int check_errors;
    int answers_waiting;
    int cycle_count;
    int burst_left;
    int issued_items;
    logic signed [sbs_pkg::FIELD_W-1:0] stim_vals [sbs_pkg::TABLE_DEPTH];

    sorted_table_binary_search_unit DUT (.*);

    sbs_search_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .entry_index     (entry_index),
        .entry_value     (entry_value),
        .search_key      (search_key),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .done            (done),
        .found           (found),
        .position        (position),
        .errors          (check_errors),
        .answers_waiting (answers_waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic idle(input int cycles);
        start <= 1'b0;
        req_type <= 1'($urandom);
        entry_index <= sbs_pkg::IDX_W'($urandom);
        entry_value <= $urandom;
        search_key <= $urandom;
        repeat (cycles) @(posedge clk);
    endtask

    // one transaction, then a gap when the current burst runs out
    task automatic issue(input logic kind, input logic [sbs_pkg::IDX_W-1:0] idx,
                         input logic signed [sbs_pkg::FIELD_W-1:0] val,
                         input logic signed [sbs_pkg::FIELD_W-1:0] key);
        start <= 1'b1;
        req_type <= kind;
        entry_index <= idx;
        entry_value <= val;
        search_key <= key;
        do @(posedge clk); while (busy);
        issued_items++;
        burst_left--;
        if (burst_left <= 0)
        begin
            idle(($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4));
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic write_entry(input logic [sbs_pkg::IDX_W-1:0] idx,
                               input logic signed [sbs_pkg::FIELD_W-1:0] val);
        stim_vals[idx] = val;
        issue(sbs_pkg::REQ_WRITE, idx, val, $urandom);
    endtask

    task automatic search_for(input logic signed [sbs_pkg::FIELD_W-1:0] key);
        issue(sbs_pkg::REQ_SEARCH, sbs_pkg::IDX_W'($urandom), $urandom, key);
    endtask

    // drain all answers, then give queued writes time to finish
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (answers_waiting != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic set_config(input logic [sbs_pkg::CNT_W-1:0] count, input logic mode);
        cfg_wr_en <= 1'b1;
        cfg_index <= sbs_pkg::REG_ENTRIES;
        cfg_wdata <= count;
        @(posedge clk);
        cfg_index <= sbs_pkg::REG_MODE;
        cfg_wdata <= {(sbs_pkg::CFG_DATA_W-1)'($urandom), mode};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // ascending values with frequent repeats; a full table ends on the top value
    task automatic fill_sorted(input int n, input longint base, input int step_hi);
        longint v;
        v = base;
        for (int i = 0; i < n; i++)
        begin
            if (i > 0 && $urandom_range(0, 3) != 0)
                v += $urandom_range(1, step_hi);
            if (v > MAX_L)
                v = MAX_L;
            if (n == sbs_pkg::TABLE_DEPTH && i == n - 1)
                v = MAX_L;
            write_entry(sbs_pkg::IDX_W'(i), sbs_pkg::FIELD_W'(v));
        end
    endtask

    function automatic logic signed [sbs_pkg::FIELD_W-1:0] pick_key(input int n);
        int r;
        int k;
        r = $urandom_range(0, 9);
        if (n == 0 || r < 2)
            return $urandom;
        k = $urandom_range(0, n - 1);
        if (r < 7)
            return stim_vals[k];
        if (r == 7)
            return stim_vals[k] + 1;
        if (r == 8)
            return stim_vals[k] - 1;
        return $urandom_range(0, 1) ? MAX_VALUE : MIN_VALUE;
    endfunction

    task automatic run_phase();
        int     r;
        int     count;
        int     span;
        logic   mode;
        longint base;
        r = $urandom_range(0, 99);
        if (r < 5)
            count = 0;
        else if (r < 12)
            count = $urandom_range(1000, 2047);
        else if (r < 22)
            count = $urandom_range(17, 64);
        else
            count = $urandom_range(1, 16);
        mode = 1'($urandom);
        span = (count > sbs_pkg::TABLE_DEPTH) ? sbs_pkg::TABLE_DEPTH : count;
        settle();
        set_config(sbs_pkg::CNT_W'(count), mode);
        if (span > 0 && span <= 64)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                base = MIN_L + $urandom_range(0, 20);
            else if (r == 1)
                base = MAX_L - $urandom_range(0, 20);
            else
                base = longint'(int'($urandom));
            fill_sorted(span, base, $urandom_range(0, 1) ? 3 : 1000);
        end
        repeat ($urandom_range(8, 40))
        begin
            r = $urandom_range(0, 19);
            if (r < 3)
                write_entry(sbs_pkg::IDX_W'($urandom), $urandom);
            else if (r == 3 && span > 0)
                write_entry(sbs_pkg::IDX_W'($urandom_range(0, span - 1)), $urandom);
            else
                search_for(pick_key(span));
        end
    endtask

    initial
    begin
        int random_start;
        rst_n <= 1'b0;
        start <= 1'b0;
        req_type <= sbs_pkg::REQ_WRITE;
        entry_index <= '0;
        entry_value <= '0;
        search_key <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= sbs_pkg::REG_ENTRIES;
        cfg_wdata <= '0;
        issued_items = 0;
        burst_left = $urandom_range(1, 40);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table
        set_config('0, sbs_pkg::MODE_EXACT);
        search_for(MIN_VALUE);
        search_for(MAX_VALUE);
        settle();
        set_config('0, sbs_pkg::MODE_LEFT);
        search_for('0);

        // whole table, extremes at both ends
        settle();
        set_config(sbs_pkg::CNT_W'(sbs_pkg::TABLE_DEPTH), sbs_pkg::MODE_EXACT);
        fill_sorted(sbs_pkg::TABLE_DEPTH, MIN_L, 4000000);
        search_for(stim_vals[0]);
        search_for(stim_vals[sbs_pkg::TABLE_DEPTH-1]);
        search_for(stim_vals[512]);
        search_for(stim_vals[512] + 1);
        settle();
        set_config(sbs_pkg::CNT_W'(sbs_pkg::TABLE_DEPTH), sbs_pkg::MODE_LEFT);
        search_for(stim_vals[0]);
        search_for(stim_vals[sbs_pkg::TABLE_DEPTH-1]);
        search_for(stim_vals[300]);
        search_for(stim_vals[300] - 1);

        // count above the table depth saturates
        settle();
        set_config('1, sbs_pkg::MODE_LEFT);
        search_for(MAX_VALUE);
        settle();
        set_config(sbs_pkg::CNT_W'(sbs_pkg::TABLE_DEPTH + 1), sbs_pkg::MODE_EXACT);
        search_for(stim_vals[700]);

        // unsorted entries
        settle();
        set_config(sbs_pkg::CNT_W'(3), sbs_pkg::MODE_EXACT);
        write_entry(sbs_pkg::IDX_W'(0), 32'sd5);
        write_entry(sbs_pkg::IDX_W'(1), -32'sd7);
        write_entry(sbs_pkg::IDX_W'(2), 32'sd3);
        search_for(32'sd3);
        search_for(32'sd5);
        search_for(-32'sd7);
        settle();
        set_config(sbs_pkg::CNT_W'(3), sbs_pkg::MODE_LEFT);
        search_for(32'sd5);
        search_for(-32'sd7);

        random_start = issued_items;
        while (issued_items < random_start + RANDOM_ITEMS)
            run_phase();
        settle();

        if (check_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

endmodule
